/* rtl/lir_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the linear interpolation resampler
// no dependencies; imported by every module of the block

package lir_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_RUN     = 64;

    localparam int RATE_W    = 18;
    localparam int LEN_W     = 20;
    localparam int IDX_W     = 26;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int USER_W = 2;
    localparam int RUN_W  = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;

    localparam int USER_BLOCK_END = 0;
    localparam int USER_DROPPED   = 1;

    // multiplier operands are signed, one guard bit above the widest value
    localparam int MUL_A_W = ((IDX_W > SAMPLE_BITS + 1) ? IDX_W : SAMPLE_BITS + 1) + 1;
    localparam int MUL_B_W = RATE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int DIV_W     = MUL_A_W - 1 + RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [RATE_W-1:0] SOURCE_RATE_RST  = RATE_W'(48000);
    localparam logic [RATE_W-1:0] TARGET_RATE_RST  = RATE_W'(16000);
    localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST = LEN_W'(16000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_RATE  = 2'd0,
        REG_TARGET_RATE  = 2'd1,
        REG_BLOCK_LENGTH = 2'd2
    } lir_reg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [RATE_W-1:0] divisor;
    } lir_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [RATE_W-1:0] remainder;
    } lir_div_rsp_t;

endpackage

/* rtl/lir_mul.sv */
`timescale 1ns / 1ps
// shared signed multiplier with a registered product
// depends on lir_pkg

module lir_mul
    import lir_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  p
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign p = prod_reg;

endmodule

/* rtl/lir_div.sv */
`timescale 1ns / 1ps
// shared restoring divider, one quotient bit per cycle
// depends on lir_pkg

module lir_div
    import lir_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  lir_div_req_t req,
    output lir_div_rsp_t rsp
);

    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [RATE_W-1:0]    dsr_reg, dsr_next;
    logic                 done_reg, done_next;
    logic [RATE_W:0]      trial;
    logic [RATE_W:0]      diff;

    always_comb begin
        trial      = {rem_reg, quo_reg[DIV_W-1]};
        diff       = trial - {1'b0, dsr_reg};
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        done_next  = 1'b0;
        if (req.start) begin
            quo_next   = req.dividend;
            rem_next   = '0;
            dsr_next   = req.divisor;
            count_next = DIV_CNT_W'(DIV_W);
        end else if (count_reg != '0) begin
            // borrow clear means trial >= divisor
            if (!diff[RATE_W]) begin
                rem_next = diff[RATE_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[RATE_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/linear_interp_resampler.sv */
`timescale 1ns / 1ps
// linear interpolation resampler: one input transaction at a time; a multiply and divide
// pass runs on the shared multiplier and 44-step divider
// a block start adds one pass, every non-final transaction one pass for its run end;
// each result: a position pass, an interpolation pass if fractional, and any output stall
// back in ST_IDLE via ST_FINISH after the last result is loaded or an empty run is found
// reset: synchronous aresetn, restores default config; depends on lir_pkg, lir_mul, lir_div

module linear_interp_resampler
    import lir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,  // in_sample
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,  // out_sample
    output logic                 m_axis_tlast,  // run_end
    output logic [USER_W-1:0]    m_axis_tuser   // block_end, dropped
);

    localparam int WIDE_W = SAMPLE_BITS + 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOT_MUL,
        ST_TOT_DIV,
        ST_TOT_WAIT,
        ST_HI_MUL,
        ST_HI_DIV,
        ST_HI_WAIT,
        ST_CHECK,
        ST_POS_MUL,
        ST_POS_DIV,
        ST_POS_WAIT,
        ST_INT_MUL,
        ST_INT_DIV,
        ST_INT_WAIT,
        ST_EMIT,
        ST_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [RATE_W-1:0]        src_reg, src_next;
    logic [RATE_W-1:0]        tgt_reg, tgt_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [SAMPLE_BITS-1:0]   prev_reg, prev_next;
    logic [SAMPLE_BITS-1:0]   x_reg, x_next;
    logic [SAMPLE_BITS-1:0]   v_reg, v_next;
    logic [LEN_W-1:0]         seen_reg, seen_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         hi_reg, hi_next;
    logic [IDX_W-1:0]         total_reg, total_next;
    logic                     last_reg, last_next;
    logic [RATE_W-1:0]        r_reg, r_next;
    logic                     neg_reg, neg_next;
    logic [RUN_W-1:0]         run_reg, run_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0]   m_sample_reg, m_sample_next;
    logic                     m_last_reg, m_last_next;
    logic                     m_block_reg, m_block_next;
    logic                     m_drop_reg, m_drop_next;

    logic [RATE_W-1:0]        src_eff;
    logic [RATE_W-1:0]        tgt_eff;
    logic [LEN_W-1:0]         len_eff;
    logic [LEN_W-1:0]         len_m1;
    logic signed [SAMPLE_BITS:0] step_s;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]        p_abs;
    lir_div_req_t             div_req;
    lir_div_rsp_t             div_rsp;
    logic [IDX_W-1:0]         total_sat;
    logic [WIDE_W-1:0]        frac_pos;
    logic [WIDE_W-1:0]        frac_mag;
    logic [WIDE_W-1:0]        v_sum;
    logic [IDX_W:0]           idx_inc;
    logic                     range_end;
    logic                     run_full;
    logic                     out_free;

    assign src_eff = (src_reg == '0) ? RATE_W'(1) : src_reg;
    assign tgt_eff = (tgt_reg == '0) ? RATE_W'(1) : tgt_reg;
    assign len_eff = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign len_m1  = len_eff - 1'b1;

    assign step_s = signed'({x_reg[SAMPLE_BITS-1], x_reg})
                  - signed'({prev_reg[SAMPLE_BITS-1], prev_reg});

    always_comb begin
        unique case (state_reg)
            ST_TOT_MUL: begin
                mul_a = MUL_A_W'(len_eff);
                mul_b = MUL_B_W'(tgt_eff);
            end
            ST_HI_MUL: begin
                mul_a = MUL_A_W'(seen_reg);
                mul_b = MUL_B_W'(tgt_eff);
            end
            ST_POS_MUL: begin
                mul_a = MUL_A_W'(idx_reg);
                mul_b = MUL_B_W'(src_eff);
            end
            ST_INT_MUL: begin
                mul_a = MUL_A_W'(step_s);
                mul_b = MUL_B_W'(r_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lir_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign p_abs = mul_p[PROD_W-1] ? PROD_W'(-mul_p) : PROD_W'(mul_p);

    always_comb begin
        div_req.start = (state_reg == ST_TOT_DIV) || (state_reg == ST_HI_DIV)
                     || (state_reg == ST_POS_DIV) || (state_reg == ST_INT_DIV);
        div_req.dividend = p_abs[DIV_W-1:0];
        div_req.divisor  = ((state_reg == ST_TOT_DIV) || (state_reg == ST_HI_DIV))
                         ? src_eff : tgt_eff;
    end

    lir_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign total_sat = (|div_rsp.quotient[DIV_W-1:IDX_W]) ? '1
                     : div_rsp.quotient[IDX_W-1:0];

    // floor of step * r / tgt from magnitude quotient and remainder
    assign frac_pos = WIDE_W'(div_rsp.quotient[SAMPLE_BITS:0]);
    assign frac_mag = frac_pos + WIDE_W'(div_rsp.remainder != '0);
    assign v_sum    = {{2{prev_reg[SAMPLE_BITS-1]}}, prev_reg}
                    + (neg_reg ? (~frac_mag + 1'b1) : frac_pos);

    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign range_end = idx_inc >= {1'b0, hi_reg};
    assign run_full  = run_reg == RUN_W'(MAX_RUN - 1);
    assign out_free  = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next    = state_reg;
        src_next      = src_reg;
        tgt_next      = tgt_reg;
        len_next      = len_reg;
        prev_next     = prev_reg;
        x_next        = x_reg;
        v_next        = v_reg;
        seen_next     = seen_reg;
        idx_next      = idx_reg;
        hi_next       = hi_reg;
        total_next    = total_reg;
        last_next     = last_reg;
        r_next        = r_reg;
        neg_next      = neg_reg;
        run_next      = run_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_sample_next = m_sample_reg;
        m_last_next   = m_last_reg;
        m_block_next  = m_block_reg;
        m_drop_next   = m_drop_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SOURCE_RATE:  src_next = cfg_wdata[RATE_W-1:0];
                REG_TARGET_RATE:  tgt_next = cfg_wdata[RATE_W-1:0];
                REG_BLOCK_LENGTH: len_next = cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    x_next    = s_axis_tdata[SAMPLE_BITS-1:0];
                    last_next = seen_reg >= len_m1;
                    run_next  = '0;
                    if (seen_reg == '0) begin
                        state_next = ST_TOT_MUL;
                    end else if (seen_reg >= len_m1) begin
                        hi_next    = total_reg;
                        state_next = ST_CHECK;
                    end else begin
                        state_next = ST_HI_MUL;
                    end
                end
            end
            ST_TOT_MUL: state_next = ST_TOT_DIV;
            ST_TOT_DIV: state_next = ST_TOT_WAIT;
            ST_TOT_WAIT: begin
                if (div_rsp.done) begin
                    total_next = total_sat;
                    idx_next   = '0;
                    if (last_reg) begin
                        hi_next    = total_sat;
                        state_next = ST_CHECK;
                    end else begin
                        state_next = ST_HI_MUL;
                    end
                end
            end
            ST_HI_MUL: state_next = ST_HI_DIV;
            ST_HI_DIV: state_next = ST_HI_WAIT;
            ST_HI_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient >= DIV_W'(total_reg)) begin
                        hi_next = total_reg;
                    end else begin
                        hi_next = div_rsp.quotient[IDX_W-1:0] + 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = (idx_reg < hi_reg) ? ST_POS_MUL : ST_FINISH;
            end
            ST_POS_MUL: state_next = ST_POS_DIV;
            ST_POS_DIV: state_next = ST_POS_WAIT;
            ST_POS_WAIT: begin
                if (div_rsp.done) begin
                    r_next = div_rsp.remainder;
                    if ((div_rsp.remainder == '0) || (div_rsp.quotient >= DIV_W'(len_m1))) begin
                        v_next     = x_reg;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_INT_MUL;
                    end
                end
            end
            ST_INT_MUL: state_next = ST_INT_DIV;
            ST_INT_DIV: begin
                neg_next   = mul_p[PROD_W-1];
                state_next = ST_INT_WAIT;
            end
            ST_INT_WAIT: begin
                if (div_rsp.done) begin
                    v_next     = v_sum[SAMPLE_BITS-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = v_reg;
                    m_last_next   = range_end || run_full;
                    m_block_next  = last_reg && (range_end || run_full);
                    m_drop_next   = run_full && !range_end;
                    idx_next      = idx_inc[IDX_W-1:0];
                    run_next      = run_reg + 1'b1;
                    state_next    = (range_end || run_full) ? ST_FINISH : ST_CHECK;
                end
            end
            ST_FINISH: begin
                prev_next = x_reg;
                if (last_reg) begin
                    seen_next = '0;
                    idx_next  = '0;
                end else begin
                    seen_next = seen_reg + 1'b1;
                    if (idx_reg < hi_reg) begin
                        idx_next = hi_reg;
                    end
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            src_reg     <= SOURCE_RATE_RST;
            tgt_reg     <= TARGET_RATE_RST;
            len_reg     <= BLOCK_LENGTH_RST;
            prev_reg    <= '0;
            seen_reg    <= '0;
            idx_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            src_reg     <= src_next;
            tgt_reg     <= tgt_next;
            len_reg     <= len_next;
            prev_reg    <= prev_next;
            seen_reg    <= seen_next;
            idx_reg     <= idx_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg        <= x_next;
        v_reg        <= v_next;
        hi_reg       <= hi_next;
        last_reg     <= last_next;
        r_reg        <= r_next;
        neg_reg      <= neg_next;
        run_reg      <= run_next;
        m_sample_reg <= m_sample_next;
        m_last_reg   <= m_last_next;
        m_block_reg  <= m_block_next;
        m_drop_reg   <= m_drop_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = DATA_W'(m_sample_reg);
    assign m_axis_tlast  = m_last_reg;

    always_comb begin
        m_axis_tuser                 = '0;
        m_axis_tuser[USER_BLOCK_END] = m_block_reg;
        m_axis_tuser[USER_DROPPED]   = m_drop_reg;
    end

`ifndef SYNTHESIS
    a_idx_within_total: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= total_reg)
        else $error("output index beyond block total");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction accepted while busy");

    a_drop_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[USER_DROPPED] |-> m_axis_tlast)
        else $error("dropped flag on a result that does not end its run");

    a_block_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[USER_BLOCK_END] |-> m_axis_tlast)
        else $error("block end on a result that does not end its run");
`endif

endmodule
